// ===== src/playfair_digraph_cipher_core_defines.svh =====
// ----------------------------------------------------------------------------
// Playfair cipher core assertion macros
// Shared property templates for the port-level checker, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_CORE_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_CORE_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define PDC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("pdc port check failed");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define PDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("pdc port check failed");

`endif

// ===== src/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Playfair cipher package
// Letter codes, square geometry, queue item types and the small helper
// functions used by the front and back parts of the cipher core.
// ----------------------------------------------------------------------------
package pdc_pkg;

    // Letter index a=0..z=25.
    typedef logic [4:0] t_letter;

    localparam t_letter LETTER_I    = 5'd8;
    localparam t_letter LETTER_J    = 5'd9;
    localparam t_letter LETTER_Z    = 5'd25;
    localparam t_letter ALPHABET    = 5'd26;
    localparam t_letter CELLS       = 5'd25;
    localparam t_letter LAST_LETTER = 5'd25;
    localparam int      USED_PAD    = 32 - 26;

    // Input kind codes as they arrive on the port.
    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_DIGRAPH = 2'd2;

    // Classified operation carried through the queue.
    typedef enum logic [1:0] {
        OP_KEY     = 2'd0,
        OP_END     = 2'd1,
        OP_DIGRAPH = 2'd2
    } t_op;

    typedef struct packed {
        t_op     op;
        t_letter first;
        t_letter second;
    } t_item;

    // Head of the queue as seen by the back part.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

    // Row and column of a square cell, each 0..4.
    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } t_cell;

    // Saturate out-of-range letters to z and read j as i.
    function automatic t_letter clean_letter(input t_letter l);
        t_letter v;
        v = (l >= ALPHABET) ? LETTER_Z : l;
        if (v == LETTER_J) begin
            v = LETTER_I;
        end
        return v;
    endfunction

    // Split a cell number 0..24 into row and column.
    function automatic t_cell cell_of(input t_letter p);
        t_cell c;
        if (p >= 5'd20) begin
            c.row = 3'd4;
        end else if (p >= 5'd15) begin
            c.row = 3'd3;
        end else if (p >= 5'd10) begin
            c.row = 3'd2;
        end else if (p >= 5'd5) begin
            c.row = 3'd1;
        end else begin
            c.row = 3'd0;
        end
        c.col = 3'(p - ((5'(c.row) << 2) + 5'(c.row)));
        return c;
    endfunction

    // Cell number of a row and column.
    function automatic t_letter cell_index(input logic [2:0] row, input logic [2:0] col);
        return (5'(row) << 2) + 5'(row) + 5'(col);
    endfunction

    // Step one place around a row or column of five, forward or backward.
    function automatic logic [2:0] step5(input logic [2:0] v, input logic back);
        logic [2:0] s;
        if (back) begin
            s = (v == 3'd0) ? 3'd4 : v - 3'd1;
        end else begin
            s = (v == 3'd4) ? 3'd0 : v + 3'd1;
        end
        return s;
    endfunction

endpackage

// ===== src/pdc_front.sv =====
// ----------------------------------------------------------------------------
// Playfair cipher front end
// Accepts commands, classifies them and cleans digraph letters, and holds
// them in a small queue until the back end takes them.
// ----------------------------------------------------------------------------
module pdc_front #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_kind,
    input  logic [4:0]           i_first_letter,
    input  logic [4:0]           i_second_letter,
    input  logic                 i_pop,
    output pdc_pkg::t_queue_out  o_queue
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pdc_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             kind_ok;
    pdc_pkg::t_item   item_in;

    // Classify the incoming command; kind 3 is accepted and dropped.
    always_comb begin
        item_in.op     = pdc_pkg::OP_KEY;
        item_in.first  = i_first_letter;
        item_in.second = i_second_letter;
        kind_ok        = 1'b1;
        unique case (i_kind)
            pdc_pkg::KIND_KEY: begin
                item_in.op = pdc_pkg::OP_KEY;
            end
            pdc_pkg::KIND_END: begin
                item_in.op = pdc_pkg::OP_END;
            end
            pdc_pkg::KIND_DIGRAPH: begin
                item_in.op     = pdc_pkg::OP_DIGRAPH;
                item_in.first  = pdc_pkg::clean_letter(i_first_letter);
                item_in.second = pdc_pkg::clean_letter(i_second_letter);
            end
            default: begin
                kind_ok = 1'b0;
            end
        endcase
    end

    assign busy = (r_count == CNT_W'(DEPTH));
    assign push = start && !busy && kind_ok;

    // Queue pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item_in;
        end
    end

    assign o_queue.valid = (r_count != '0);
    assign o_queue.item  = r_mem[r_rd_ptr];

endmodule

// ===== src/pdc_back.sv =====
// ----------------------------------------------------------------------------
// Playfair cipher back end
// Holds the 5x5 square and the letter position map, places key letters,
// runs the key-end fill sequence and transforms digraphs.
// ----------------------------------------------------------------------------
module pdc_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_direction,
    input  pdc_pkg::t_queue_out       i_queue,
    output logic                      o_pop,
    output logic                      o_strobe,
    output logic [4:0]                o_first_out,
    output logic [4:0]                o_second_out
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FILL = 4'b0010,
        S_POS  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [25:0]      r_used, n_used;
    pdc_pkg::t_letter r_count, n_count;
    logic             r_closed, n_closed;
    pdc_pkg::t_letter r_k, n_k;

    pdc_pkg::t_letter sq_mem  [25];
    pdc_pkg::t_letter pos_mem [26];
    pdc_pkg::t_letter r_pos_a, r_pos_b;
    pdc_pkg::t_letter r_out_a, r_out_b;

    logic [25:0]      base_used;
    pdc_pkg::t_letter base_count;
    pdc_pkg::t_letter cand;
    logic             try_place;
    logic             place_ok;
    logic [31:0]      used_ext;
    logic [31:0]      used_set;
    logic             rd_pos;
    logic             rd_sq;
    pdc_pkg::t_cell   cell_a, cell_b;
    pdc_pkg::t_letter addr_a, addr_b;

    // Sequencer: dispatch queue items, run the fill walk, step a digraph.
    always_comb begin
        n_state    = r_state;
        n_closed   = r_closed;
        n_k        = r_k;
        base_used  = r_used;
        base_count = r_count;
        cand       = i_queue.item.first;
        try_place  = 1'b0;
        rd_pos     = 1'b0;
        rd_sq      = 1'b0;
        o_pop      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_queue.valid) begin
                    o_pop = 1'b1;
                    unique case (i_queue.item.op)
                        pdc_pkg::OP_KEY: begin
                            // A key letter after key end starts a fresh square.
                            if (r_closed) begin
                                base_used  = '0;
                                base_count = '0;
                                n_closed   = 1'b0;
                            end
                            try_place = 1'b1;
                        end
                        pdc_pkg::OP_END: begin
                            if (!r_closed) begin
                                n_k     = '0;
                                n_state = S_FILL;
                            end
                        end
                        pdc_pkg::OP_DIGRAPH: begin
                            if (r_closed) begin
                                rd_pos  = 1'b1;
                                n_state = S_POS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                cand      = r_k;
                try_place = 1'b1;
                if (r_k == pdc_pkg::LAST_LETTER) begin
                    n_closed = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_POS: begin
                rd_sq   = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Letter placement shared by key letters and the fill walk.
    always_comb begin
        used_ext = {{pdc_pkg::USED_PAD{1'b0}}, base_used};
        used_set = 32'd1 << cand;
        place_ok = try_place && (cand < pdc_pkg::ALPHABET) && (cand != pdc_pkg::LETTER_J)
                   && (base_count < pdc_pkg::CELLS) && !used_ext[cand];
        n_used   = place_ok ? (base_used | used_set[25:0]) : base_used;
        n_count  = place_ok ? (base_count + 1'b1) : base_count;
    end

    // Digraph rule: same row, same column, or rectangle.
    always_comb begin
        cell_a = pdc_pkg::cell_of(r_pos_a);
        cell_b = pdc_pkg::cell_of(r_pos_b);
        priority if (cell_a.row == cell_b.row) begin
            addr_a = pdc_pkg::cell_index(cell_a.row, pdc_pkg::step5(cell_a.col, i_direction));
            addr_b = pdc_pkg::cell_index(cell_b.row, pdc_pkg::step5(cell_b.col, i_direction));
        end else if (cell_a.col == cell_b.col) begin
            addr_a = pdc_pkg::cell_index(pdc_pkg::step5(cell_a.row, i_direction), cell_a.col);
            addr_b = pdc_pkg::cell_index(pdc_pkg::step5(cell_b.row, i_direction), cell_b.col);
        end else begin
            addr_a = pdc_pkg::cell_index(cell_a.row, cell_b.col);
            addr_b = pdc_pkg::cell_index(cell_b.row, cell_a.col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_count  <= '0;
            r_closed <= 1'b0;
            r_k      <= '0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_count  <= n_count;
            r_closed <= n_closed;
            r_k      <= n_k;
        end
    end

    // Square and position map writes, registered reads.
    always_ff @(posedge i_clk) begin
        if (place_ok) begin
            sq_mem[base_count] <= cand;
            pos_mem[cand]      <= base_count;
        end
        if (rd_pos) begin
            r_pos_a <= pos_mem[i_queue.item.first];
            r_pos_b <= pos_mem[i_queue.item.second];
        end
        if (rd_sq) begin
            r_out_a <= sq_mem[addr_a];
            r_out_b <= sq_mem[addr_b];
        end
    end

    assign o_strobe     = (r_state == S_EMIT);
    assign o_first_out  = r_out_a;
    assign o_second_out = r_out_b;

endmodule

// ===== src/playfair_digraph_cipher_core.sv =====
// ----------------------------------------------------------------------------
// Playfair digraph cipher core
// Top level: command front end, queue, square store and transform back end,
// plus the direction register.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy rises only when
// the QUEUE_DEPTH-entry command queue is full. The back end drains the queue
// one command at a time: a key letter is placed when it is taken, a key end
// runs the fill sequencer (it walks all 26 letters, one per cycle), and a
// digraph goes through position map read, square read and result. The result
// of a digraph is shown for exactly one cycle with o_strobe and cannot be
// held off, so it must be captured on that cycle. No result comes from key
// items, kind 3, or a digraph sent before the key is closed. Write the
// direction register only while no command is pending.
module playfair_digraph_cipher_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_kind,
    input  logic [4:0] i_first_letter,
    input  logic [4:0] i_second_letter,
    output logic       o_strobe,
    output logic [4:0] o_first_out,
    output logic [4:0] o_second_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    logic                r_direction;
    logic                pop;
    pdc_pkg::t_queue_out queue_head;

    // Direction register: one configuration transaction per write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_direction <= i_cfg_data;
        end
    end

    pdc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_first_letter  (i_first_letter),
        .i_second_letter (i_second_letter),
        .i_pop           (pop),
        .o_queue         (queue_head)
    );

    pdc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_direction  (r_direction),
        .i_queue      (queue_head),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_first_out  (o_first_out),
        .o_second_out (o_second_out)
    );

endmodule

// ===== src/pdc_checker.sv =====
// ----------------------------------------------------------------------------
// Playfair cipher port checker
// Watches the result ports of the cipher core: result spacing and letter
// range. Attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`include "playfair_digraph_cipher_core_defines.svh"

module pdc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_strobe,
    input logic [4:0] o_first_out,
    input logic [4:0] o_second_out
);

    // A digraph passes through the idle, position and emit states in the back end, so results are spaced.
    `PDC_ASSERT_NEXT(a_strobe_gap1, o_strobe, !o_strobe)
    `PDC_ASSERT_NEXT(a_strobe_gap2, o_strobe, ##1 !o_strobe)

    // Results come from a filled square: letters only, and never j.
    `PDC_ASSERT_NOW(a_first_letter, o_strobe, (o_first_out <= 5'd25) && (o_first_out != 5'd9))
    `PDC_ASSERT_NOW(a_second_letter, o_strobe, (o_second_out <= 5'd25) && (o_second_out != 5'd9))

endmodule

bind playfair_digraph_cipher_core pdc_checker u_pdc_checker (.*);
